@@ hdl/footprint_collision_check_unit_assert.svh @@
// Assertion macros shared by the collision check modules.
// Both expect ports named clock and reset in the module that uses them.
`ifndef FOOTPRINT_COLLISION_CHECK_UNIT_ASSERT_SVH
`define FOOTPRINT_COLLISION_CHECK_UNIT_ASSERT_SVH

// cond implies check in the same cycle
`define FCC_ASSERT_HOLDS(lbl, cond, check) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (check)) \
      else $error("fcc assertion failed");

// cond implies check in the next cycle
`define FCC_ASSERT_NEXT(lbl, cond, check) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (check)) \
      else $error("fcc assertion failed");

`endif

@@ hdl/fcc_pkg.sv @@
`timescale 1ns / 1ps
package fcc_pkg;

   localparam int SUBCELLS        = 10;
   localparam int HEADING_CLASSES = 72;
   localparam int MAX_FOOTPRINT   = 64;
   localparam int GRID_CELLS      = 65536;
   localparam int FRACTION_BITS   = 8;

   localparam int ENTRIES   = SUBCELLS * SUBCELLS * HEADING_CLASSES;
   localparam int OFF_DEPTH = ENTRIES * MAX_FOOTPRINT;

   // fixed field widths
   localparam int POS_W   = 18;
   localparam int HEAD_W  = 16;
   localparam int TIDX_W  = 13;
   localparam int SLOT_W  = 6;
   localparam int OFS_W   = 6;
   localparam int LENF_W  = 7;
   localparam int CADDR_W = 16;
   localparam int DIM_W   = 11;

   // derived widths
   localparam int CELL_W  = POS_W - FRACTION_BITS;
   localparam int SUB_W   = (SUBCELLS > 1) ? $clog2(SUBCELLS) : 1;
   localparam int HC_W    = (HEADING_CLASSES > 1) ? $clog2(HEADING_CLASSES) : 1;
   localparam int PIDX_W  = (SUBCELLS > 1) ? $clog2(SUBCELLS * SUBCELLS) : 1;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OFF_AW  = (OFF_DEPTH > 1) ? $clog2(OFF_DEPTH) : 1;
   localparam int LEN_W   = $clog2(MAX_FOOTPRINT + 1);
   localparam int OCC_AW  = $clog2(GRID_CELLS);
   localparam int CRD_W   = CELL_W + 2;
   localparam int GADDR_W = CRD_W - 1 + DIM_W + 1;

   typedef enum logic [1:0] {
      MODE_WR_OFFSET = 2'd0,
      MODE_WR_LENGTH = 2'd1,
      MODE_WR_CELL   = 2'd2,
      MODE_QUERY     = 2'd3
   } mode_type;

   typedef enum logic [0:0] {
      CSR_MAP_WIDTH  = 1'b0,
      CSR_MAP_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_SUB,
      ST_IDX,
      ST_LEN_RD,
      ST_LEN_WAIT,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] len;
   } walk_cmd_type;

   typedef struct packed {
      logic done;
      logic collision_free;
      logic left_map;
   } walk_status_type;

endpackage

@@ hdl/footprint_collision_check_unit.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   mode, position, heading, table and grid writes
// rsp      out        rsp_valid/rsp_stall   collision_free, left_map (queries only)
// csr      in         csr_wr_en             csr_index, csr_wr_data (map width, height)
//
// A load beat is taken while the sequencer is idle. A query walks the stored
// footprint length, clipped to MAX_FOOTPRINT; the walk reads one offset
// and one grid cell per cycle through the table and grid memory ports.
// A query stops early at the first cell that is occupied or off the map.
// Reset clears control only; the table and grid hold nothing until loaded.
// A result waits in the rsp register under stall while the next beat is taken.
`include "footprint_collision_check_unit_assert.svh"
module footprint_collision_check_unit
   import fcc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_mode,
   input  logic [POS_W-1:0]         req_pos_x,
   input  logic [POS_W-1:0]         req_pos_y,
   input  logic [HEAD_W-1:0]        req_heading,
   input  logic [TIDX_W-1:0]        req_table_index,
   input  logic [SLOT_W-1:0]        req_slot,
   input  logic signed [OFS_W-1:0]  req_offset_x,
   input  logic signed [OFS_W-1:0]  req_offset_y,
   input  logic [LENF_W-1:0]        req_footprint_length,
   input  logic [CADDR_W-1:0]       req_cell_address,
   input  logic                     req_occupied,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_collision_free,
   output logic                     rsp_left_map,
   input  logic                     csr_wr_en,
   input  logic [0:0]               csr_index,
   input  logic [DIM_W-1:0]         csr_wr_data
);

   localparam int SUBP_W  = FRACTION_BITS + SUB_W + 1;
   localparam int HEADP_W = HEAD_W + HC_W + 1;
   localparam logic [DIM_W-1:0] MapDimReset = DIM_W'(256);

   state_type state_ff, state_in;

   logic [DIM_W-1:0] map_width_ff, map_width_in;
   logic [DIM_W-1:0] map_height_ff, map_height_in;

   logic [CELL_W-1:0]        cx0_ff, cx0_in;
   logic [CELL_W-1:0]        cy0_ff, cy0_in;
   logic [FRACTION_BITS-1:0] frac_x_ff, frac_x_in;
   logic [FRACTION_BITS-1:0] frac_y_ff, frac_y_in;
   logic [HEAD_W-1:0]        heading_ff, heading_in;
   logic [SUB_W-1:0]         sx_ff, sx_in;
   logic [SUB_W-1:0]         sy_ff, sy_in;
   logic [HC_W-1:0]          hc_ff, hc_in;
   logic [PIDX_W-1:0]        pidx_ff, pidx_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free_ff, rsp_free_in;
   logic rsp_left_ff, rsp_left_in;

   logic [SUBP_W-1:0]  sub_x_prod;
   logic [SUBP_W-1:0]  sub_y_prod;
   logic [HEADP_W-1:0] head_prod;

   logic req_accept;
   logic load_query;
   logic rsp_load;
   logic rsp_slot_free;

   logic               off_we;
   logic [OFF_AW-1:0]  off_addr;
   logic [OFF_AW-1:0]  off_wr_addr;
   logic [2*OFS_W-1:0] off_rd_data;
   logic [OFF_AW-1:0]  walk_off_addr;
   logic               len_we;
   logic [IDX_W-1:0]   len_addr;
   logic [LENF_W-1:0]  len_rd_data;
   logic               occ_we;
   logic [OCC_AW-1:0]  occ_addr;
   logic               occ_rd_data;
   logic [OCC_AW-1:0]  walk_occ_addr;

   walk_cmd_type    walk_cmd;
   walk_status_type walk_status;

   assign req_accept    = req_valid && !req_stall;
   assign rsp_slot_free = !rsp_valid_ff || !rsp_stall;

   // ---------------- control sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_mode == MODE_QUERY)) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT:    state_in = ST_SUB;
         ST_SUB:      state_in = ST_IDX;
         ST_IDX:      state_in = ST_LEN_RD;
         ST_LEN_RD:   state_in = ST_LEN_WAIT;
         ST_LEN_WAIT: state_in = ST_WALK;
         ST_WALK: begin
            if (walk_status.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall      = 1'b1;
      load_query     = 1'b0;
      walk_cmd.start = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            load_query = req_valid && (req_mode == MODE_QUERY);
         end
         ST_LEN_WAIT: walk_cmd.start = 1'b1;
         ST_DONE:     rsp_load = rsp_slot_free;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- configuration ----------------
   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  map_width_in  = csr_wr_data;
            CSR_MAP_HEIGHT: map_height_in = csr_wr_data;
            default: begin
               map_width_in = map_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= MapDimReset;
         map_height_ff <= MapDimReset;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   // ---------------- footprint index ----------------
   assign cx0_in     = req_pos_x[POS_W-1:FRACTION_BITS];
   assign cy0_in     = req_pos_y[POS_W-1:FRACTION_BITS];
   assign frac_x_in  = req_pos_x[FRACTION_BITS-1:0];
   assign frac_y_in  = req_pos_y[FRACTION_BITS-1:0];
   assign heading_in = req_heading;

   assign sub_x_prod = SUBP_W'(frac_x_ff) * SUBP_W'(SUBCELLS);
   assign sub_y_prod = SUBP_W'(frac_y_ff) * SUBP_W'(SUBCELLS);
   assign head_prod  = HEADP_W'(heading_ff) * HEADP_W'(HEADING_CLASSES);
   assign sx_in      = SUB_W'(sub_x_prod >> FRACTION_BITS);
   assign sy_in      = SUB_W'(sub_y_prod >> FRACTION_BITS);
   assign hc_in      = HC_W'(head_prod >> HEAD_W);
   assign pidx_in    = PIDX_W'(PIDX_W'(sy_ff) * PIDX_W'(SUBCELLS) + PIDX_W'(sx_ff));
   assign idx_in     = IDX_W'(IDX_W'(pidx_ff) * IDX_W'(HEADING_CLASSES) + IDX_W'(hc_ff));

   always_ff @(posedge clock) begin
      if (load_query) begin
         cx0_ff     <= cx0_in;
         cy0_ff     <= cy0_in;
         frac_x_ff  <= frac_x_in;
         frac_y_ff  <= frac_y_in;
         heading_ff <= heading_in;
      end
      if (state_ff == ST_SPLIT) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         hc_ff <= hc_in;
      end
      if (state_ff == ST_SUB) begin
         pidx_ff <= pidx_in;
      end
      if (state_ff == ST_IDX) begin
         idx_ff <= idx_in;
      end
   end

   // stored lengths above the list size walk the full list
   assign walk_cmd.len = (32'(len_rd_data) > 32'(MAX_FOOTPRINT)) ?
                         LEN_W'(MAX_FOOTPRINT) : LEN_W'(len_rd_data);

   // ---------------- memories ----------------
   // loads come only while idle, so each port serves either a write or the walk
   assign off_we = req_accept && (req_mode == MODE_WR_OFFSET)
                   && (32'(req_table_index) < 32'(ENTRIES))
                   && (32'(req_slot) < 32'(MAX_FOOTPRINT));
   assign off_wr_addr = OFF_AW'(OFF_AW'(req_table_index) * OFF_AW'(MAX_FOOTPRINT)
                                + OFF_AW'(req_slot));
   assign off_addr = off_we ? off_wr_addr : walk_off_addr;

   assign len_we   = req_accept && (req_mode == MODE_WR_LENGTH)
                     && (32'(req_table_index) < 32'(ENTRIES));
   assign len_addr = len_we ? IDX_W'(req_table_index) : idx_ff;

   assign occ_we   = req_accept && (req_mode == MODE_WR_CELL)
                     && (32'(req_cell_address) < 32'(GRID_CELLS));
   assign occ_addr = occ_we ? OCC_AW'(req_cell_address) : walk_occ_addr;

   fcc_ram #(
      .DEPTH (OFF_DEPTH),
      .WIDTH (2*OFS_W)
   ) u_off_ram (
      .clock   (clock),
      .wr_en   (off_we),
      .addr    (off_addr),
      .wr_data ({req_offset_y, req_offset_x}),
      .rd_data (off_rd_data)
   );

   fcc_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (LENF_W)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .addr    (len_addr),
      .wr_data (req_footprint_length),
      .rd_data (len_rd_data)
   );

   fcc_ram #(
      .DEPTH (GRID_CELLS),
      .WIDTH (1)
   ) u_occ_ram (
      .clock   (clock),
      .wr_en   (occ_we),
      .addr    (occ_addr),
      .wr_data (req_occupied),
      .rd_data (occ_rd_data)
   );

   fcc_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .cmd         (walk_cmd),
      .idx         (idx_ff),
      .cx0         (cx0_ff),
      .cy0         (cy0_ff),
      .map_width   (map_width_ff),
      .map_height  (map_height_ff),
      .off_rd_addr (walk_off_addr),
      .off_rd_data (off_rd_data),
      .occ_rd_addr (walk_occ_addr),
      .occ_rd_data (occ_rd_data),
      .status      (walk_status)
   );

   // ---------------- result register ----------------
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_free_in  = walk_status.collision_free;
   assign rsp_left_in  = walk_status.left_map;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_free_ff <= rsp_free_in;
         rsp_left_ff <= rsp_left_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_collision_free = rsp_free_ff;
   assign rsp_left_map       = rsp_left_ff;

   `FCC_ASSERT_NEXT(top_query_enters_split, req_accept && (req_mode == MODE_QUERY), state_ff == ST_SPLIT)
   `FCC_ASSERT_HOLDS(top_walk_done_in_walk, walk_status.done, state_ff == ST_WALK)
   `FCC_ASSERT_HOLDS(top_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)

endmodule

@@ hdl/fcc_ram.sv @@
`timescale 1ns / 1ps
module fcc_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wr_data,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/fcc_walk.sv @@
`timescale 1ns / 1ps
`include "footprint_collision_check_unit_assert.svh"
module fcc_walk
   import fcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  walk_cmd_type          cmd,
   input  logic [IDX_W-1:0]      idx,
   input  logic [CELL_W-1:0]     cx0,
   input  logic [CELL_W-1:0]     cy0,
   input  logic [DIM_W-1:0]      map_width,
   input  logic [DIM_W-1:0]      map_height,
   output logic [OFF_AW-1:0]     off_rd_addr,
   input  logic [2*OFS_W-1:0]    off_rd_data,
   output logic [OCC_AW-1:0]     occ_rd_addr,
   input  logic                  occ_rd_data,
   output walk_status_type       status
);

   logic              active_ff, active_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  iss_ff, iss_in;
   logic [OFF_AW-1:0] off_addr_ff, off_addr_in;
   logic              s1_vld_ff, s1_vld_in;
   logic              s2_vld_ff, s2_vld_in;
   logic              s3_vld_ff, s3_vld_in;
   logic              s4_vld_ff, s4_vld_in;
   logic [CRD_W-2:0]  cx_ff, cx_in;
   logic [CRD_W-2:0]  cy_ff, cy_in;
   logic              oob2_ff, oob2_in;
   logic              oob3_ff, oob3_in;
   logic              oob4_ff, oob4_in;
   logic [GADDR_W-1:0] gaddr_ff, gaddr_in;
   logic              done_ff, done_in;
   logic              free_ff, free_in;
   logic              left_ff, left_in;

   logic signed [CRD_W-1:0] cx_s;
   logic signed [CRD_W-1:0] cy_s;
   logic issue;
   logic fault;
   logic drained;

   // stage 1: offset beat back from the table, form the covered cell
   assign cx_s = $signed({2'b00, cx0}) + CRD_W'($signed(off_rd_data[OFS_W-1:0]));
   assign cy_s = $signed({2'b00, cy0}) + CRD_W'($signed(off_rd_data[2*OFS_W-1:OFS_W]));
   assign cx_in = cx_s[CRD_W-2:0];
   assign cy_in = cy_s[CRD_W-2:0];
   assign oob2_in = cx_s[CRD_W-1] | cy_s[CRD_W-1]
                  | (32'(cx_s[CRD_W-2:0]) >= 32'(map_width))
                  | (32'(cy_s[CRD_W-2:0]) >= 32'(map_height));

   // stage 2: grid address
   assign gaddr_in = GADDR_W'(cy_ff) * GADDR_W'(map_width) + GADDR_W'(cx_ff);
   assign oob3_in  = oob2_ff;

   // stage 3: grid read, address past the grid counts as off the map
   assign occ_rd_addr = OCC_AW'(gaddr_ff);
   assign oob4_in     = oob3_ff | (32'(gaddr_ff) >= 32'(GRID_CELLS));

   // stage 4: verdict, taken in list order
   assign fault = s4_vld_ff & (oob4_ff | occ_rd_data);

   assign issue   = active_ff && (iss_ff != len_ff);
   assign drained = active_ff && !issue && !s1_vld_ff && !s2_vld_ff && !s3_vld_ff
                    && !s4_vld_ff;

   always_comb begin
      active_in   = active_ff;
      len_in      = len_ff;
      iss_in      = issue ? iss_ff + LEN_W'(1) : iss_ff;
      off_addr_in = issue ? off_addr_ff + OFF_AW'(1) : off_addr_ff;
      s1_vld_in   = issue;
      s2_vld_in   = s1_vld_ff;
      s3_vld_in   = s2_vld_ff;
      s4_vld_in   = s3_vld_ff;
      done_in     = 1'b0;
      free_in     = free_ff;
      left_in     = left_ff;
      if (cmd.start) begin
         active_in   = 1'b1;
         len_in      = cmd.len;
         iss_in      = '0;
         off_addr_in = OFF_AW'(OFF_AW'(idx) * OFF_AW'(MAX_FOOTPRINT));
         s1_vld_in   = 1'b0;
         s2_vld_in   = 1'b0;
         s3_vld_in   = 1'b0;
         s4_vld_in   = 1'b0;
      end else if (fault) begin
         active_in = 1'b0;
         s1_vld_in = 1'b0;
         s2_vld_in = 1'b0;
         s3_vld_in = 1'b0;
         s4_vld_in = 1'b0;
         done_in   = 1'b1;
         free_in   = 1'b0;
         left_in   = oob4_ff;
      end else if (drained) begin
         active_in = 1'b0;
         done_in   = 1'b1;
         free_in   = 1'b1;
         left_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
         iss_ff    <= '0;
         len_ff    <= '0;
      end else begin
         active_ff <= active_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
         s4_vld_ff <= s4_vld_in;
         done_ff   <= done_in;
         iss_ff    <= iss_in;
         len_ff    <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      off_addr_ff <= off_addr_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      oob2_ff     <= oob2_in;
      oob3_ff     <= oob3_in;
      oob4_ff     <= oob4_in;
      gaddr_ff    <= gaddr_in;
      free_ff     <= free_in;
      left_ff     <= left_in;
   end

   assign off_rd_addr           = off_addr_ff;
   assign status.done           = done_ff;
   assign status.collision_free = free_ff;
   assign status.left_map       = left_ff;

   `FCC_ASSERT_HOLDS(walk_iss_within_len, active_ff, iss_ff <= len_ff)
   `FCC_ASSERT_HOLDS(walk_start_when_idle, cmd.start, !active_ff)
   `FCC_ASSERT_HOLDS(walk_done_stops, done_ff, !active_ff && !s1_vld_ff)

endmodule

@@ tb/sv/footprint_collision_check_unit_checker.sv @@
`timescale 1ns / 1ps
module footprint_collision_check_unit_checker
   import fcc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [1:0]               req_mode,
   input  logic [POS_W-1:0]         req_pos_x,
   input  logic [POS_W-1:0]         req_pos_y,
   input  logic [HEAD_W-1:0]        req_heading,
   input  logic [TIDX_W-1:0]        req_table_index,
   input  logic [SLOT_W-1:0]        req_slot,
   input  logic signed [OFS_W-1:0]  req_offset_x,
   input  logic signed [OFS_W-1:0]  req_offset_y,
   input  logic [LENF_W-1:0]        req_footprint_length,
   input  logic [CADDR_W-1:0]       req_cell_address,
   input  logic                     req_occupied,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     rsp_collision_free,
   input  logic                     rsp_left_map,
   input  logic                     csr_wr_en,
   input  logic [0:0]               csr_index,
   input  logic [DIM_W-1:0]         csr_wr_data,
   output int                       mismatches,
   output int                       pending,
   output int                       verdicts_checked
);

   typedef struct packed {
      logic collision_free;
      logic left_map;
   } verdict_t;

   // predictor copy of the block state
   bit [2*OFS_W-1:0] fp_offsets [OFF_DEPTH];
   bit [LENF_W-1:0]  fp_lengths [ENTRIES];
   bit               occ_grid [GRID_CELLS];
   int               grid_w;
   int               grid_h;

   verdict_t verdict_q [$];
   verdict_t want;

   function automatic int sext_offset(input bit [OFS_W-1:0] v);
      return v[OFS_W-1] ? int'(v) - (1 << OFS_W) : int'(v);
   endfunction

   function automatic verdict_t walk_footprint(input logic [POS_W-1:0] px,
                                               input logic [POS_W-1:0] py,
                                               input logic [HEAD_W-1:0] hd);
      int        cx0, cy0, sx, sy, hc, idx, len, cx, cy;
      longint    addr;
      bit [11:0] e;
      verdict_t  v;
      v.collision_free = 1'b1;
      v.left_map = 1'b0;
      cx0 = int'(px) >> FRACTION_BITS;
      cy0 = int'(py) >> FRACTION_BITS;
      sx = ((int'(px) % (1 << FRACTION_BITS)) * SUBCELLS) >> FRACTION_BITS;
      sy = ((int'(py) % (1 << FRACTION_BITS)) * SUBCELLS) >> FRACTION_BITS;
      hc = (int'(hd) * HEADING_CLASSES) >> HEAD_W;
      idx = (sy * SUBCELLS + sx) * HEADING_CLASSES + hc;
      len = (idx < ENTRIES) ? int'(fp_lengths[idx]) : 0;
      if (len > MAX_FOOTPRINT) len = MAX_FOOTPRINT;
      for (int i = 0; i < len; i++) begin
         e = fp_offsets[idx * MAX_FOOTPRINT + i];
         cx = cx0 + sext_offset(e[OFS_W-1:0]);
         cy = cy0 + sext_offset(e[2*OFS_W-1:OFS_W]);
         if (cx < 0 || cy < 0 || cx >= grid_w || cy >= grid_h) begin
            v.collision_free = 1'b0;
            v.left_map = 1'b1;
            break;
         end
         addr = longint'(cy) * grid_w + cx;
         // oversized maps can push the address past the grid
         if (addr >= GRID_CELLS) begin
            v.collision_free = 1'b0;
            v.left_map = 1'b1;
            break;
         end
         if (occ_grid[addr]) begin
            v.collision_free = 1'b0;
            break;
         end
      end
      return v;
   endfunction

   initial begin
      mismatches = 0;
      pending = 0;
      verdicts_checked = 0;
      grid_w = 256;
      grid_h = 256;
   end

   always @(posedge clock) begin
      if (reset) begin
         grid_w = 256;
         grid_h = 256;
         verdict_q.delete();
         pending = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index_type'(csr_index) == CSR_MAP_WIDTH) grid_w = int'(csr_wr_data);
            else grid_h = int'(csr_wr_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: result beat with no query outstanding (free %b left %b)",
                        $time, rsp_collision_free, rsp_left_map);
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               verdicts_checked++;
               if (rsp_collision_free !== want.collision_free) begin
                  $display("%0t: collision_free expected %b actual %b",
                           $time, want.collision_free, rsp_collision_free);
                  mismatches++;
               end
               if (rsp_left_map !== want.left_map) begin
                  $display("%0t: left_map expected %b actual %b",
                           $time, want.left_map, rsp_left_map);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (mode_type'(req_mode))
               MODE_WR_OFFSET: begin
                  if (req_table_index < ENTRIES && req_slot < MAX_FOOTPRINT)
                     fp_offsets[int'(req_table_index) * MAX_FOOTPRINT + int'(req_slot)] =
                        {req_offset_y, req_offset_x};
               end
               MODE_WR_LENGTH: begin
                  if (req_table_index < ENTRIES)
                     fp_lengths[req_table_index] = req_footprint_length;
               end
               MODE_WR_CELL: begin
                  if (req_cell_address < GRID_CELLS)
                     occ_grid[req_cell_address] = req_occupied;
               end
               default: begin
                  verdict_q.push_back(walk_footprint(req_pos_x, req_pos_y, req_heading));
               end
            endcase
         end
         pending = verdict_q.size();
      end
   end

endmodule

@@ tb/sv/footprint_collision_check_unit_test.sv @@
`timescale 1ns / 1ps
module footprint_collision_check_unit_test;
   import fcc_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_BEATS = 1300;
   localparam int DRAIN_CYCLES = 100;
   localparam int LONG_HOLD    = 600;
   localparam int NUM_MAPS     = 10;

   typedef struct {
      mode_type               mode;
      logic [POS_W-1:0]       pos_x;
      logic [POS_W-1:0]       pos_y;
      logic [HEAD_W-1:0]      heading;
      logic [TIDX_W-1:0]      table_index;
      logic [SLOT_W-1:0]      slot;
      logic signed [OFS_W-1:0] offset_x;
      logic signed [OFS_W-1:0] offset_y;
      logic [LENF_W-1:0]      footprint_length;
      logic [CADDR_W-1:0]     cell_address;
      logic                   occupied;
   } req_beat_t;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [1:0]               req_mode;
   logic [POS_W-1:0]         req_pos_x;
   logic [POS_W-1:0]         req_pos_y;
   logic [HEAD_W-1:0]        req_heading;
   logic [TIDX_W-1:0]        req_table_index;
   logic [SLOT_W-1:0]        req_slot;
   logic signed [OFS_W-1:0]  req_offset_x;
   logic signed [OFS_W-1:0]  req_offset_y;
   logic [LENF_W-1:0]        req_footprint_length;
   logic [CADDR_W-1:0]       req_cell_address;
   logic                     req_occupied;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_collision_free;
   logic                     rsp_left_map;
   logic                     csr_wr_en;
   logic [0:0]               csr_index;
   logic [DIM_W-1:0]         csr_wr_data;

   int mismatches;
   int pending;
   int verdicts_checked;

   // what has been loaded so far, so queries only touch written entries
   bit [2*OFS_W-1:0] offsets_loaded [int];
   bit [LENF_W-1:0]  lengths_loaded [int];
   bit               cells_loaded [int];

   int  map_w = 256;
   int  map_h = 256;
   int  beats_counted = 0;
   int  cycle_count = 0;
   int  holds_done = 0;
   bit  tx_quiet = 1'b0;
   bit  rx_quiet = 1'b0;
   bit  long_hold_req = 1'b0;

   int phase_w [NUM_MAPS] = '{16, 1, 0, 9, 1024, 2047, 37, 256, 5, 2047};
   int phase_h [NUM_MAPS] = '{16, 1, 9, 0, 64, 2047, 23, 256, 200, 1};

   footprint_collision_check_unit u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_heading          (req_heading),
      .req_table_index      (req_table_index),
      .req_slot             (req_slot),
      .req_offset_x         (req_offset_x),
      .req_offset_y         (req_offset_y),
      .req_footprint_length (req_footprint_length),
      .req_cell_address     (req_cell_address),
      .req_occupied         (req_occupied),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_collision_free   (rsp_collision_free),
      .rsp_left_map         (rsp_left_map),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data)
   );

   footprint_collision_check_unit_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_heading          (req_heading),
      .req_table_index      (req_table_index),
      .req_slot             (req_slot),
      .req_offset_x         (req_offset_x),
      .req_offset_y         (req_offset_y),
      .req_footprint_length (req_footprint_length),
      .req_cell_address     (req_cell_address),
      .req_occupied         (req_occupied),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_collision_free   (rsp_collision_free),
      .rsp_left_map         (rsp_left_map),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data),
      .mismatches           (mismatches),
      .pending              (pending),
      .verdicts_checked     (verdicts_checked)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count, pending);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic req_beat_t random_beat(input mode_type m);
      req_beat_t b;
      b.mode = m;
      b.pos_x = POS_W'($urandom);
      b.pos_y = POS_W'($urandom);
      b.heading = HEAD_W'($urandom);
      b.table_index = TIDX_W'($urandom);
      b.slot = SLOT_W'($urandom);
      b.offset_x = OFS_W'($urandom);
      b.offset_y = OFS_W'($urandom);
      b.footprint_length = LENF_W'($urandom);
      b.cell_address = CADDR_W'($urandom);
      b.occupied = 1'($urandom);
      return b;
   endfunction

   function automatic int pick_gap();
      int r;
      if (tx_quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 0;
      if (r < 82) return $urandom_range(1, 6);
      if (r < 95) return $urandom_range(7, 24);
      return $urandom_range(64, 127);
   endfunction

   task automatic send_beat(input req_beat_t b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode <= b.mode;
      req_pos_x <= b.pos_x;
      req_pos_y <= b.pos_y;
      req_heading <= b.heading;
      req_table_index <= b.table_index;
      req_slot <= b.slot;
      req_offset_x <= b.offset_x;
      req_offset_y <= b.offset_y;
      req_footprint_length <= b.footprint_length;
      req_cell_address <= b.cell_address;
      req_occupied <= b.occupied;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // ignored table writes do not count as work
      case (b.mode)
         MODE_WR_OFFSET: begin
            if (b.table_index < ENTRIES) begin
               offsets_loaded[int'(b.table_index) * MAX_FOOTPRINT + int'(b.slot)] =
                  {b.offset_y, b.offset_x};
               beats_counted++;
            end
         end
         MODE_WR_LENGTH: begin
            if (b.table_index < ENTRIES) begin
               lengths_loaded[int'(b.table_index)] = b.footprint_length;
               beats_counted++;
            end
         end
         MODE_WR_CELL: begin
            cells_loaded[int'(b.cell_address)] = b.occupied;
            beats_counted++;
         end
         default: beats_counted++;
      endcase
   endtask

   // loads whatever the walk of this query may read, then sends the query
   task automatic query_with_setup(input bit redefine, input bit roam);
      req_beat_t q, w;
      int        span, sx, sy, hc, idx, n, cx, cy, addr;
      bit [11:0] e;
      q = random_beat(MODE_QUERY);
      if (!roam) begin
         span = (map_w + 4 > 1023) ? 1023 : map_w + 4;
         q.pos_x[POS_W-1:FRACTION_BITS] = CELL_W'($urandom_range(0, span));
         span = (map_h + 4 > 1023) ? 1023 : map_h + 4;
         q.pos_y[POS_W-1:FRACTION_BITS] = CELL_W'($urandom_range(0, span));
      end
      sx = ((int'(q.pos_x) % (1 << FRACTION_BITS)) * SUBCELLS) >> FRACTION_BITS;
      sy = ((int'(q.pos_y) % (1 << FRACTION_BITS)) * SUBCELLS) >> FRACTION_BITS;
      hc = (int'(q.heading) * HEADING_CLASSES) >> HEAD_W;
      idx = (sy * SUBCELLS + sx) * HEADING_CLASSES + hc;
      if (redefine || !lengths_loaded.exists(idx)) begin
         w = random_beat(MODE_WR_LENGTH);
         w.table_index = TIDX_W'(idx);
         w.footprint_length = LENF_W'(pick_length());
         send_beat(w);
      end
      n = int'(lengths_loaded[idx]);
      if (n > MAX_FOOTPRINT) n = MAX_FOOTPRINT;
      for (int s = 0; s < n; s++) begin
         if (redefine || !offsets_loaded.exists(idx * MAX_FOOTPRINT + s)) begin
            w = random_beat(MODE_WR_OFFSET);
            w.table_index = TIDX_W'(idx);
            w.slot = SLOT_W'(s);
            if ($urandom_range(0, 9) < 7) begin
               w.offset_x = OFS_W'($urandom_range(0, 6) - 3);
               w.offset_y = OFS_W'($urandom_range(0, 6) - 3);
            end
            send_beat(w);
         end
      end
      for (int s = 0; s < n; s++) begin
         e = offsets_loaded[idx * MAX_FOOTPRINT + s];
         cx = (int'(q.pos_x) >> FRACTION_BITS)
              + (e[OFS_W-1] ? int'(e[OFS_W-1:0]) - 64 : int'(e[OFS_W-1:0]));
         cy = (int'(q.pos_y) >> FRACTION_BITS)
              + (e[11] ? int'(e[11:OFS_W]) - 64 : int'(e[11:OFS_W]));
         if (cx >= 0 && cy >= 0 && cx < map_w && cy < map_h) begin
            addr = cy * map_w + cx;
            if (addr < GRID_CELLS && !cells_loaded.exists(addr)) begin
               w = random_beat(MODE_WR_CELL);
               w.cell_address = CADDR_W'(addr);
               w.occupied = ($urandom_range(0, 99) < 15);
               send_beat(w);
            end
         end
      end
      send_beat(q);
   endtask

   task automatic send_noise();
      req_beat_t w;
      w = random_beat(mode_type'($urandom_range(0, 2)));
      if ($urandom_range(0, 4) == 0) w.table_index = TIDX_W'($urandom_range(ENTRIES, 8191));
      send_beat(w);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_map(input int w, input int h);
      settle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAP_WIDTH;
      csr_wr_data <= DIM_W'(w);
      @(negedge clock);
      csr_index <= CSR_MAP_HEIGHT;
      csr_wr_data <= DIM_W'(h);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      map_w = w;
      map_h = h;
   endtask

   task automatic run_directed();
      req_beat_t b;
      // empty footprint at entry 0
      b = random_beat(MODE_WR_LENGTH);
      b.table_index = 0;
      b.footprint_length = 0;
      send_beat(b);
      b = random_beat(MODE_QUERY);
      b.pos_x = 0;
      b.pos_y = 0;
      b.heading = 0;
      send_beat(b);
      // one cell on an occupied square
      b = random_beat(MODE_WR_CELL);
      b.cell_address = 5 * 256 + 5;
      b.occupied = 1'b1;
      send_beat(b);
      b = random_beat(MODE_WR_OFFSET);
      b.table_index = 0;
      b.slot = 0;
      b.offset_x = 0;
      b.offset_y = 0;
      send_beat(b);
      b = random_beat(MODE_WR_LENGTH);
      b.table_index = 0;
      b.footprint_length = 1;
      send_beat(b);
      b = random_beat(MODE_QUERY);
      b.pos_x = 5 << FRACTION_BITS;
      b.pos_y = 5 << FRACTION_BITS;
      b.heading = 0;
      send_beat(b);
      // negative column leaves the map
      b = random_beat(MODE_WR_OFFSET);
      b.table_index = 0;
      b.slot = 0;
      b.offset_x = -1;
      b.offset_y = 0;
      send_beat(b);
      b = random_beat(MODE_QUERY);
      b.pos_x = 0;
      b.pos_y = 5 << FRACTION_BITS;
      b.heading = 0;
      send_beat(b);
      // last entry: top sub-cell and heading class, extreme offsets
      b = random_beat(MODE_WR_LENGTH);
      b.table_index = ENTRIES - 1;
      b.footprint_length = 2;
      send_beat(b);
      b = random_beat(MODE_WR_OFFSET);
      b.table_index = ENTRIES - 1;
      b.slot = 0;
      b.offset_x = 31;
      b.offset_y = 31;
      send_beat(b);
      b.slot = 1;
      b.offset_x = -32;
      b.offset_y = -32;
      send_beat(b);
      b = random_beat(MODE_WR_CELL);
      b.cell_address = 131 * 256 + 131;
      b.occupied = 1'b0;
      send_beat(b);
      b.cell_address = 68 * 256 + 68;
      send_beat(b);
      b = random_beat(MODE_QUERY);
      b.pos_x = (100 << FRACTION_BITS) | 255;
      b.pos_y = (100 << FRACTION_BITS) | 255;
      b.heading = 16'hFFFF;
      send_beat(b);
      b.pos_x = '1;
      b.pos_y = '1;
      send_beat(b);
      // table writes that must be dropped, and a write to the top grid cell
      b = random_beat(MODE_WR_OFFSET);
      b.table_index = ENTRIES;
      b.slot = '1;
      send_beat(b);
      b = random_beat(MODE_WR_LENGTH);
      b.table_index = '1;
      b.footprint_length = '1;
      send_beat(b);
      b = random_beat(MODE_WR_CELL);
      b.cell_address = '1;
      b.occupied = 1'b1;
      send_beat(b);
   endtask

   // result side back-pressure
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            holds_done++;
            stall_left = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                      : $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_WR_OFFSET;
      req_pos_x = '0;
      req_pos_y = '0;
      req_heading = '0;
      req_table_index = '0;
      req_slot = '0;
      req_offset_x = '0;
      req_offset_y = '0;
      req_footprint_length = '0;
      req_cell_address = '0;
      req_occupied = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_MAP_WIDTH;
      csr_wr_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      for (int p = 0; p < NUM_MAPS; p++) begin
         set_map(phase_w[p], phase_h[p]);
         tx_quiet = (p % 3 == 1);
         rx_quiet = (p % 3 == 2);
         // receiver holds off while queries keep coming
         if (p == 0) long_hold_req = 1'b1;
         target = beats_counted + RANDOM_BEATS / NUM_MAPS;
         while (beats_counted < target) begin
            if ($urandom_range(0, 99) < 8) send_noise();
            else query_with_setup($urandom_range(0, 99) < 30, $urandom_range(0, 99) < 12);
         end
      end
      settle();

      $display("covered %0d beats, %0d query verdicts over %0d map sizes incl. zero and oversize",
               beats_counted, verdicts_checked, NUM_MAPS + 1);
      $display("long result hold-off of %0d cycles applied %0d time(s)", LONG_HOLD, holds_done);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/fcc_pkg.sv
hdl/fcc_ram.sv
hdl/fcc_walk.sv
hdl/footprint_collision_check_unit.sv
tb/sv/footprint_collision_check_unit_checker.sv
tb/sv/footprint_collision_check_unit_test.sv
